>>> hdl/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Shared constants, register indexes and width helpers for the point
// rotation core.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

    // default formats: coordinates Q16.16, axis and trig Q2.30
    localparam int PRA_COORD_WIDTH    = 32;
    localparam int PRA_TRIG_FRAC_BITS = 30;

    // intermediate arithmetic wraps at this width
    localparam int PRA_WRAP_WIDTH = 128;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_X   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Y   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Z   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_U    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_V    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AXIS_W    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COS_ANGLE = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIN_ANGLE = 3'd7;

    // clamp an intermediate width to the wrap width
    function automatic int wrap_width(input int w);
        return (w > PRA_WRAP_WIDTH) ? PRA_WRAP_WIDTH : w;
    endfunction

    // write data width covers both register formats
    function automatic int cfg_data_width(input int coord_w, input int frac_bits);
        return (coord_w > frac_bits + 2) ? coord_w : frac_bits + 2;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pra_if.sv
// ----------------------------------------------------------------------------
// pra_if
// Handshake channels of the point rotation core: input points, rotated
// results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// point channel
interface pra_point_if
    import pra_pkg::*;
#(
    parameter int COORD_WIDTH = PRA_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;

    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

// result channel
interface pra_result_if
    import pra_pkg::*;
#(
    parameter int COORD_WIDTH = PRA_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;

    modport source (output valid, out_x, out_y, out_z, clipped, input ready);
    modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// configuration write channel
interface pra_cfg_if
    import pra_pkg::*;
#(
    parameter int DATA_WIDTH = PRA_COORD_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/point_rotation_about_axis_core.sv
// ----------------------------------------------------------------------------
// point_rotation_about_axis_core
// Rotates streamed 3D points about a line through a pivot along a unit axis.
// ----------------------------------------------------------------------------
// One point enters per clock while the output is not stalled, and the
// pipeline holds on output back-pressure without losing items. It is built
// from three chained multiply levels (axis by offset, axis by dot product,
// projection by 1 - cos), each a two-stage split multiplier, plus the
// offset, reduction, accumulate and round/saturate stages. Points
// and results are signed Q16.16, axis, cosine and sine signed Q2.30; the axis
// is used as written, without normalisation. A result outside the coordinate
// range is clamped and flagged by clipped. Configuration writes are always
// accepted and should only be made while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotation_about_axis_core
    import pra_pkg::*;
#(
    parameter int COORD_WIDTH    = PRA_COORD_WIDTH,
    parameter int TRIG_FRAC_BITS = PRA_TRIG_FRAC_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pra_point_if.sink   point,
    pra_result_if.source result,
    pra_cfg_if.sink     cfg
);

    localparam int C      = COORD_WIDTH;
    localparam int F      = TRIG_FRAC_BITS;
    localparam int TW     = F + 2;
    localparam int DW     = C + 1;
    localparam int T_W    = F + 3;
    localparam int SDOT_W = wrap_width(C + F + 5);
    localparam int DOT_W  = SDOT_W - F;
    localparam int SCR_W  = wrap_width(C + F + 4);
    localparam int CR_W   = SCR_W - F;
    localparam int SPR_W  = wrap_width(TW + DOT_W);
    localparam int PR_W   = SPR_W - F;
    localparam int ACC_W  = wrap_width(C + F + 12);
    localparam int RES_W  = ACC_W - F;
    localparam int PIPE_DEPTH = 11;

    localparam logic signed [F:0]   HALF_F = {2'b01, {(F-1){1'b0}}};
    localparam logic signed [C-1:0] CMAX   = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] CMIN   = {1'b1, {(C-1){1'b0}}};

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    logic signed [C-1:0]   pivot [3];
    logic signed [TW-1:0]  axis [3];
    logic signed [TW-1:0]  cos_angle;
    logic signed [TW-1:0]  sin_angle;
    logic signed [T_W-1:0] t_val;
    logic signed [C-1:0]   pt [3];

    logic signed [DW-1:0]       d_reg [3];
    logic signed [TW+DW-1:0]    ad_prod [3][3];
    logic signed [TW+DW-1:0]    dc_prod [3];
    logic signed [SDOT_W-1:0]   dot_sum;
    logic signed [DOT_W-1:0]    dot_reg;
    logic signed [SCR_W-1:0]    cr_sum [3];
    logic signed [CR_W-1:0]     cr_reg [3];
    logic signed [ACC_W-1:0]    base_reg [3];
    logic signed [ACC_W-1:0]    base_d1_reg [3];
    logic signed [ACC_W-1:0]    base_d2_reg [3];
    logic signed [TW+DOT_W-1:0] adot_prod [3];
    logic signed [TW+CR_W-1:0]  crs_prod [3];
    logic signed [SPR_W-1:0]    pr_sum [3];
    logic signed [PR_W-1:0]     pr_reg [3];
    logic signed [ACC_W-1:0]    suma_reg [3];
    logic signed [ACC_W-1:0]    suma_d1_reg [3];
    logic signed [ACC_W-1:0]    suma_d2_reg [3];
    logic signed [T_W+PR_W-1:0] prt_prod [3];
    logic signed [ACC_W-1:0]    acc_reg [3];
    logic signed [ACC_W-1:0]    rnd_sum [3];
    logic signed [RES_W-1:0]    res [3];
    logic [2:0]                 ovf;
    logic signed [C-1:0]        out_next [3];
    logic signed [C-1:0]        out_reg [3];
    logic                       clip_reg;

    // configuration registers
    pra_cfg #(
        .COORD_WIDTH   (COORD_WIDTH),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pivot_x  (pivot[0]),
        .pivot_y  (pivot[1]),
        .pivot_z  (pivot[2]),
        .axis_u   (axis[0]),
        .axis_v   (axis[1]),
        .axis_w   (axis[2]),
        .cos_angle(cos_angle),
        .sin_angle(sin_angle)
    );

    // 1 - cos, one sign bit more than the trig format
    assign t_val = (T_W'(1) <<< F) - T_W'(cos_angle);

    // global advance: the output slot is empty or being taken
    assign en          = !vld_reg[PIPE_DEPTH-1] || result.ready;
    assign point.ready = en;

    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], point.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign pt[0] = point.in_x;
    assign pt[1] = point.in_y;
    assign pt[2] = point.in_z;

    // axis by offset products, all nine pairs
    for (genvar j = 0; j < 3; j++)
    begin : g_ad_row
        for (genvar k = 0; k < 3; k++)
        begin : g_ad_col
            pra_mul #(.WA(TW), .WB(DW)) u_mul_ad (
                .clk(clk),
                .en (en),
                .a  (axis[j]),
                .b  (d_reg[k]),
                .p  (ad_prod[j][k])
            );
        end
    end

    // dot product of axis and offset, rounded
    assign dot_sum = SDOT_W'(ad_prod[0][0]) + SDOT_W'(ad_prod[1][1])
                   + SDOT_W'(ad_prod[2][2]) + SDOT_W'(HALF_F);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg <= dot_sum[SDOT_W-1:F];
        end
    end

    // per-coordinate lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;

        // offset from pivot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i] <= DW'(pt[i]) - DW'(pivot[i]);
            end
        end

        // offset times cosine
        pra_mul #(.WA(TW), .WB(DW)) u_mul_dc (
            .clk(clk),
            .en (en),
            .a  (cos_angle),
            .b  (d_reg[i]),
            .p  (dc_prod[i])
        );

        // cross product component, rounded; pivot plus scaled offset
        assign cr_sum[i] = SCR_W'(ad_prod[I1][I2]) - SCR_W'(ad_prod[I2][I1])
                         + SCR_W'(HALF_F);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_reg[i]      <= cr_sum[i][SCR_W-1:F];
                base_reg[i]    <= (ACC_W'(pivot[i]) <<< F) + ACC_W'(dc_prod[i]);
                base_d1_reg[i] <= base_reg[i];
                base_d2_reg[i] <= base_d1_reg[i];
            end
        end

        // axis times dot, cross times sine
        pra_mul #(.WA(TW), .WB(DOT_W)) u_mul_adot (
            .clk(clk),
            .en (en),
            .a  (axis[i]),
            .b  (dot_reg),
            .p  (adot_prod[i])
        );

        pra_mul #(.WA(TW), .WB(CR_W)) u_mul_crs (
            .clk(clk),
            .en (en),
            .a  (sin_angle),
            .b  (cr_reg[i]),
            .p  (crs_prod[i])
        );

        // projection rounded; partial accumulate
        assign pr_sum[i] = SPR_W'(adot_prod[i]) + SPR_W'(HALF_F);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pr_reg[i]      <= pr_sum[i][SPR_W-1:F];
                suma_reg[i]    <= base_d2_reg[i] + ACC_W'(crs_prod[i]);
                suma_d1_reg[i] <= suma_reg[i];
                suma_d2_reg[i] <= suma_d1_reg[i];
            end
        end

        // projection times 1 - cos
        pra_mul #(.WA(T_W), .WB(PR_W)) u_mul_prt (
            .clk(clk),
            .en (en),
            .a  (t_val),
            .b  (pr_reg[i]),
            .p  (prt_prod[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[i] <= suma_d2_reg[i] + ACC_W'(prt_prod[i]);
            end
        end

        // round and clamp to the coordinate range
        assign rnd_sum[i] = acc_reg[i] + ACC_W'(HALF_F);
        assign res[i]     = rnd_sum[i][ACC_W-1:F];
        assign ovf[i]     = !((&res[i][RES_W-1:C-1]) || !(|res[i][RES_W-1:C-1]));
        assign out_next[i] = ovf[i] ? (res[i][RES_W-1] ? CMIN : CMAX) : res[i][C-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                out_reg[i] <= out_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clip_reg <= |ovf;
        end
    end

    // result item
    assign result.valid   = vld_reg[PIPE_DEPTH-1];
    assign result.out_x   = out_reg[0];
    assign result.out_y   = out_reg[1];
    assign result.out_z   = out_reg[2];
    assign result.clipped = clip_reg;

    // pipeline holds while stalled
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // an accepted item enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> vld_reg[0])
        else $error("accepted item not captured");

    // no result appears when an advance moves an empty stage into the last
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        en && !vld_reg[PIPE_DEPTH-2] |=> !result.valid)
        else $error("result item without a source item");

    // a clipped result sits on a range limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.clipped |->
            (result.out_x == CMAX || result.out_x == CMIN ||
             result.out_y == CMAX || result.out_y == CMIN ||
             result.out_z == CMAX || result.out_z == CMIN))
        else $error("clipped flag without a saturated coordinate");

endmodule

`default_nettype wire

>>> hdl/pra_mul.sv
// ----------------------------------------------------------------------------
// pra_mul
// Two-stage signed multiplier: operand b is split into a low unsigned half
// and a high signed half, partial products are registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_mul
    import pra_pkg::*;
#(
    parameter int WA = PRA_TRIG_FRAC_BITS + 2,
    parameter int WB = PRA_COORD_WIDTH + 1
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [WA-1:0]    a,
    input  wire logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0]      p
);

    localparam int LB = WB / 2;
    localparam int HB = WB - LB;

    logic signed [WA+LB:0]    plo_next;
    logic signed [WA+LB:0]    plo_reg;
    logic signed [WA+HB-1:0]  phi_next;
    logic signed [WA+HB-1:0]  phi_reg;
    logic signed [WA+WB-1:0]  p_next;
    logic signed [WA+WB-1:0]  p_reg;
    logic signed [LB:0]       b_lo;
    logic signed [HB-1:0]     b_hi;

    // split operand
    assign b_lo = $signed({1'b0, b[LB-1:0]});
    assign b_hi = $signed(b[WB-1:LB]);

    // partial products
    assign plo_next = a * b_lo;
    assign phi_next = a * b_hi;

    // recombine
    assign p_next = ((WA+WB)'(phi_reg) <<< LB) + (WA+WB)'(plo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> hdl/pra_cfg.sv
// ----------------------------------------------------------------------------
// pra_cfg
// Configuration register file: pivot point, rotation axis, cosine and sine.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_cfg
    import pra_pkg::*;
#(
    parameter int COORD_WIDTH    = PRA_COORD_WIDTH,
    parameter int TRIG_FRAC_BITS = PRA_TRIG_FRAC_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    pra_cfg_if.sink                               cfg,
    output logic signed [COORD_WIDTH-1:0]         pivot_x,
    output logic signed [COORD_WIDTH-1:0]         pivot_y,
    output logic signed [COORD_WIDTH-1:0]         pivot_z,
    output logic signed [TRIG_FRAC_BITS+1:0]      axis_u,
    output logic signed [TRIG_FRAC_BITS+1:0]      axis_v,
    output logic signed [TRIG_FRAC_BITS+1:0]      axis_w,
    output logic signed [TRIG_FRAC_BITS+1:0]      cos_angle,
    output logic signed [TRIG_FRAC_BITS+1:0]      sin_angle
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) <<< TRIG_FRAC_BITS;

    logic signed [COORD_WIDTH-1:0] pivot_x_reg;
    logic signed [COORD_WIDTH-1:0] pivot_y_reg;
    logic signed [COORD_WIDTH-1:0] pivot_z_reg;
    logic signed [TW-1:0]          axis_u_reg;
    logic signed [TW-1:0]          axis_v_reg;
    logic signed [TW-1:0]          axis_w_reg;
    logic signed [TW-1:0]          cos_reg;
    logic signed [TW-1:0]          sin_reg;
    logic signed [COORD_WIDTH-1:0] coord_data;
    logic signed [TW-1:0]          trig_data;

    // writes are never held off
    assign cfg.ready = 1'b1;

    assign coord_data = $signed(cfg.data[COORD_WIDTH-1:0]);
    assign trig_data  = $signed(cfg.data[TW-1:0]);

    // register decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
            axis_u_reg  <= '0;
            axis_v_reg  <= '0;
            axis_w_reg  <= TRIG_ONE;
            cos_reg     <= TRIG_ONE;
            sin_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PIVOT_X:   pivot_x_reg <= coord_data;
                REG_PIVOT_Y:   pivot_y_reg <= coord_data;
                REG_PIVOT_Z:   pivot_z_reg <= coord_data;
                REG_AXIS_U:    axis_u_reg  <= trig_data;
                REG_AXIS_V:    axis_v_reg  <= trig_data;
                REG_AXIS_W:    axis_w_reg  <= trig_data;
                REG_COS_ANGLE: cos_reg     <= trig_data;
                REG_SIN_ANGLE: sin_reg     <= trig_data;
                default:       ;
            endcase
        end
    end

    assign pivot_x   = pivot_x_reg;
    assign pivot_y   = pivot_y_reg;
    assign pivot_z   = pivot_z_reg;
    assign axis_u    = axis_u_reg;
    assign axis_v    = axis_v_reg;
    assign axis_w    = axis_w_reg;
    assign cos_angle = cos_reg;
    assign sin_angle = sin_reg;

endmodule

`default_nettype wire

>>> dv/tb_point_rotation_about_axis_core.sv
// ----------------------------------------------------------------------------
// tb_point_rotation_about_axis_core
// Self-checking bench for the point rotation core. A short stimulus table covers
// identity after reset, half and quarter turns with clamping, extreme pivots, a
// non-unit axis and trig values off the unit circle. Random phases follow, with
// unit axes built from random angles, raw register values and extreme settings.
// Each result is compared with its table value or with a fixed-point model of
// the rotation, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_rotation_about_axis_core;
    import pra_pkg::*;

    localparam int CW           = PRA_COORD_WIDTH;
    localparam int FRAC         = PRA_TRIG_FRAC_BITS;
    localparam int DW           = cfg_data_width(PRA_COORD_WIDTH, PRA_TRIG_FRAC_BITS);
    localparam int CLK_PERIOD   = 8;
    localparam int PIPE_LAT     = 11;
    localparam int RAND_ITEMS   = 1600;
    localparam int RAND_PHASES  = 8;
    localparam int END_WAIT     = 200000;
    localparam int LIMIT_CYCLES = 1600000;
    localparam int MAX_PRINTS   = 20;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [FRAC+1:0] trig_t;
    typedef logic signed [127:0]    acc_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   clipped;
    } rot_t;

    typedef enum logic {ROW_REG, ROW_POINT} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [DW-1:0]              data;
        coord_t                     x;
        coord_t                     y;
        coord_t                     z;
        logic                       known;
        rot_t                       want;
    } plan_row_t;

    localparam coord_t C_MAX     = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN     = {1'b1, {(CW-1){1'b0}}};
    localparam trig_t  T_ONE     = trig_t'(1) << FRAC;
    localparam trig_t  T_NEG_ONE = -(trig_t'(1) << FRAC);

    logic clk;
    logic rst_n;

    pra_point_if  #(.COORD_WIDTH(CW)) pt_ch ();
    pra_result_if #(.COORD_WIDTH(CW)) res_ch ();
    pra_cfg_if    #(.DATA_WIDTH(DW))  cfg_ch ();

    point_rotation_about_axis_core #(
        .COORD_WIDTH    (CW),
        .TRIG_FRAC_BITS (FRAC)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (pt_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // register copy used by the rotation model
    logic [DW-1:0] reg_shadow [0:7];
    rot_t          pending [$];
    plan_row_t     plan [$];
    rot_t          got_want;
    int            errors;
    int            n_points;
    int            n_clipped;
    int            n_writes;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("point_rotation_about_axis_core: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR %s: got %h, expected %h", what, got, want);
    endtask

    // round half up, dropping the trig fraction bits
    function automatic acc_t round_frac(input acc_t v);
        acc_t h;
        h = 1;
        h = h <<< (FRAC - 1);
        return (v + h) >>> FRAC;
    endfunction

    // rotation of one point about the configured line, 128-bit wrapping
    function automatic rot_t rotate_point(input coord_t qx, input coord_t qy,
                                          input coord_t qz);
        acc_t   piv [3];
        acc_t   ax [3];
        acc_t   dd [3];
        acc_t   cr [3];
        coord_t outs [3];
        acc_t   cs, sn, tt, dot, pr, acc, r, hi, lo;
        coord_t cv;
        trig_t  tv;
        rot_t   res;
        int     i;
        for (i = 0; i < 3; i++)
        begin
            cv = reg_shadow[REG_PIVOT_X + i][CW-1:0];
            piv[i] = cv;
            tv = reg_shadow[REG_AXIS_U + i][FRAC+1:0];
            ax[i] = tv;
        end
        dd[0] = qx;
        dd[1] = qy;
        dd[2] = qz;
        for (i = 0; i < 3; i++)
            dd[i] = dd[i] - piv[i];
        tv = reg_shadow[REG_COS_ANGLE][FRAC+1:0];
        cs = tv;
        tv = reg_shadow[REG_SIN_ANGLE][FRAC+1:0];
        sn = tv;
        tt = 1;
        tt = (tt <<< FRAC) - cs;
        dot   = round_frac(ax[0] * dd[0] + ax[1] * dd[1] + ax[2] * dd[2]);
        cr[0] = round_frac(ax[1] * dd[2] - ax[2] * dd[1]);
        cr[1] = round_frac(ax[2] * dd[0] - ax[0] * dd[2]);
        cr[2] = round_frac(ax[0] * dd[1] - ax[1] * dd[0]);
        hi = C_MAX;
        lo = C_MIN;
        res.clipped = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            pr  = round_frac(ax[i] * dot);
            acc = (piv[i] <<< FRAC) + dd[i] * cs + cr[i] * sn + pr * tt;
            r   = round_frac(acc);
            if (r > hi)
            begin
                r = hi;
                res.clipped = 1'b1;
            end
            else if (r < lo)
            begin
                r = lo;
                res.clipped = 1'b1;
            end
            outs[i] = r[CW-1:0];
        end
        res.x = outs[0];
        res.y = outs[1];
        res.z = outs[2];
        return res;
    endfunction

    // idle length: mostly none, sometimes short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t small_coord();
        logic [CW-1:0] v;
        v = $urandom_range(0, 32'h0200_0000);
        return v - 32'h0100_0000;
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // any value in [-1.0, +1.0]
    function automatic trig_t raw_trig();
        logic [FRAC+1:0] v;
        v = $urandom_range(0, 32'h8000_0000);
        return v - T_ONE;
    endfunction

    function automatic trig_t extreme_trig();
        case ($urandom_range(0, 2))
            0: return T_NEG_ONE;
            1: return 0;
            default: return T_ONE;
        endcase
    endfunction

    function automatic trig_t to_q30(input real r);
        trig_t q;
        q = $rtoi(r * 1073741824.0);
        return q;
    endfunction

    // result channel back-pressure
    initial
    begin : sink_stall
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm != 0)
            begin
                calm--;
                res_ch.ready <= 1'b1;
            end
            else if (stall != 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 2)
                    calm = $urandom_range(50, 300);
                else
                    stall = idle_len();
            end
        end
    end

    // result check against the oldest expected item
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending.size() == 0)
                report_mismatch("result with no point outstanding",
                                64'(res_ch.out_x), '0);
            else
            begin
                got_want = pending.pop_front();
                if (res_ch.out_x !== got_want.x)
                    report_mismatch("out_x", 64'(res_ch.out_x), 64'(got_want.x));
                if (res_ch.out_y !== got_want.y)
                    report_mismatch("out_y", 64'(res_ch.out_y), 64'(got_want.y));
                if (res_ch.out_z !== got_want.z)
                    report_mismatch("out_z", 64'(res_ch.out_z), 64'(got_want.z));
                if (res_ch.clipped !== got_want.clipped)
                    report_mismatch("clipped", 64'(res_ch.clipped),
                                    64'(got_want.clipped));
            end
        end
    end

    // send one point, with an optional idle gap before it
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic known, input rot_t want, input bit calm);
        int   gap;
        rot_t exp_item;
        gap = calm ? 0 : idle_len();
        if (gap != 0)
        begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.in_x  <= x;
        pt_ch.in_y  <= y;
        pt_ch.in_z  <= z;
        do @(posedge clk); while (!pt_ch.ready);
        exp_item = known ? want : rotate_point(x, y, z);
        pending.push_back(exp_item);
        n_points++;
        if (exp_item.clipped)
            n_clipped++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    // register write; valid stays up when another write follows
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [DW-1:0] val, input bit more);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        reg_shadow[idx] = val;
        n_writes++;
        if (!more)
            cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input coord_t px, input coord_t py, input coord_t pz,
                              input trig_t au, input trig_t av, input trig_t aw,
                              input trig_t c, input trig_t s);
        drain();
        write_reg(REG_PIVOT_X, px, 1'b1);
        write_reg(REG_PIVOT_Y, py, 1'b1);
        write_reg(REG_PIVOT_Z, pz, 1'b1);
        write_reg(REG_AXIS_U, au, 1'b1);
        write_reg(REG_AXIS_V, av, 1'b1);
        write_reg(REG_AXIS_W, aw, 1'b1);
        write_reg(REG_COS_ANGLE, c, 1'b1);
        write_reg(REG_SIN_ANGLE, s, 1'b0);
    endtask

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [DW-1:0] val);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = val;
        return r;
    endfunction

    function automatic plan_row_t pt_row(input coord_t x, input coord_t y,
                                         input coord_t z);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_POINT;
        r.x    = x;
        r.y    = y;
        r.z    = z;
        return r;
    endfunction

    function automatic plan_row_t known_row(input coord_t x, input coord_t y,
                                            input coord_t z, input coord_t ex,
                                            input coord_t ey, input coord_t ez,
                                            input logic clip);
        plan_row_t r;
        r         = pt_row(x, y, z);
        r.known   = 1'b1;
        r.want.x  = ex;
        r.want.y  = ey;
        r.want.z  = ez;
        r.want.clipped = clip;
        return r;
    endfunction

    // one random phase: new registers, then a run of points
    task automatic random_phase(input int style, input int count);
        coord_t px, py, pz, qx, qy, qz;
        trig_t  au, av, aw, c, s;
        real    th, ph, ang;
        int     k;
        bit     calm;
        th  = $urandom_range(0, 31415) / 10000.0;
        ph  = $urandom_range(0, 62831) / 10000.0;
        ang = $urandom_range(0, 62831) / 10000.0;
        case (style) inside
            0, 3:
            begin
                // unit axis and angle on the unit circle
                au = to_q30($sin(th) * $cos(ph));
                av = to_q30($sin(th) * $sin(ph));
                aw = to_q30($cos(th));
                c  = to_q30($cos(ang));
                s  = to_q30($sin(ang));
                px = (style == 0) ? small_coord() : coord_t'($urandom);
                py = (style == 0) ? small_coord() : coord_t'($urandom);
                pz = (style == 0) ? small_coord() : coord_t'($urandom);
            end
            1:
            begin
                au = raw_trig();
                av = raw_trig();
                aw = raw_trig();
                c  = raw_trig();
                s  = raw_trig();
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
            default:
            begin
                au = extreme_trig();
                av = extreme_trig();
                aw = extreme_trig();
                c  = extreme_trig();
                s  = extreme_trig();
                px = extreme_coord();
                py = extreme_coord();
                pz = extreme_coord();
            end
        endcase
        set_config(px, py, pz, au, av, aw, c, s);
        for (k = 0; k < count; k++)
        begin
            calm = (k >= count / 2) && (k < count / 2 + 40);
            // in the raw style, a quarter into the run, the sender holds off until the pipeline is empty
            if (k == count / 4 && style == 1)
                drain();
            if ($urandom_range(0, 7) == 0 || style == 1 || style == 3)
            begin
                qx = $urandom;
                qy = $urandom;
                qz = $urandom;
            end
            else if (style == 0)
            begin
                qx = small_coord();
                qy = small_coord();
                qz = small_coord();
            end
            else
            begin
                qx = $urandom_range(0, 1) ? extreme_coord() : coord_t'($urandom);
                qy = $urandom_range(0, 1) ? extreme_coord() : coord_t'($urandom);
                qz = $urandom_range(0, 1) ? extreme_coord() : coord_t'($urandom);
            end
            send_point(qx, qy, qz, 1'b0, '0, calm);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        plan_row_t row;
        int        ph;
        int        waited;
        errors    = 0;
        n_points  = 0;
        n_clipped = 0;
        n_writes  = 0;
        reg_shadow[REG_PIVOT_X]   = '0;
        reg_shadow[REG_PIVOT_Y]   = '0;
        reg_shadow[REG_PIVOT_Z]   = '0;
        reg_shadow[REG_AXIS_U]    = '0;
        reg_shadow[REG_AXIS_V]    = '0;
        reg_shadow[REG_AXIS_W]    = T_ONE;
        reg_shadow[REG_COS_ANGLE] = T_ONE;
        reg_shadow[REG_SIN_ANGLE] = '0;
        rst_n        <= 1'b0;
        pt_ch.valid  <= 1'b0;
        pt_ch.in_x   <= '0;
        pt_ch.in_y   <= '0;
        pt_ch.in_z   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_PIVOT_X;
        cfg_ch.data  <= '0;

        // after reset: identity about the z axis
        plan.push_back(known_row(0, 0, 0, 0, 0, 0, 1'b0));
        plan.push_back(known_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
        plan.push_back(known_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
        plan.push_back(known_row(1, -1, 32'h0001_0000, 1, -1, 32'h0001_0000, 1'b0));
        plan.push_back(known_row(C_MAX, C_MIN, 32'h0000_8000,
                                 C_MAX, C_MIN, 32'h0000_8000, 1'b0));
        // half turn about z: x and y negate, a most negative x or y clamps
        plan.push_back(reg_row(REG_COS_ANGLE, T_NEG_ONE));
        plan.push_back(known_row(32'h0003_0000, 32'hfffe_0000, 32'h0005_0000,
                                 32'hfffd_0000, 32'h0002_0000, 32'h0005_0000, 1'b0));
        plan.push_back(known_row(C_MIN, 5, 7, C_MAX, -5, 7, 1'b1));
        plan.push_back(known_row(C_MAX, C_MIN, C_MIN, -C_MAX, C_MAX, C_MIN, 1'b1));
        // quarter turn about z: (x, y) becomes (-y, x)
        plan.push_back(reg_row(REG_COS_ANGLE, 0));
        plan.push_back(reg_row(REG_SIN_ANGLE, T_ONE));
        plan.push_back(known_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                 32'hfffe_0000, 32'h0001_0000, 32'h0003_0000, 1'b0));
        plan.push_back(known_row(0, C_MIN, 0, C_MAX, 0, 0, 1'b1));
        // extreme pivot, axis not of unit length, trig off the unit circle
        plan.push_back(reg_row(REG_PIVOT_X, C_MAX));
        plan.push_back(reg_row(REG_PIVOT_Y, C_MIN));
        plan.push_back(reg_row(REG_PIVOT_Z, 32'h1234_5678));
        plan.push_back(reg_row(REG_AXIS_U, T_ONE));
        plan.push_back(reg_row(REG_AXIS_V, T_ONE));
        plan.push_back(reg_row(REG_COS_ANGLE, 32'h2000_0000));
        plan.push_back(pt_row(0, 0, 0));
        plan.push_back(pt_row(C_MAX, C_MIN, 0));
        plan.push_back(pt_row(C_MIN, C_MAX, C_MAX));
        // minus 45 degrees about -x
        plan.push_back(reg_row(REG_AXIS_U, T_NEG_ONE));
        plan.push_back(reg_row(REG_AXIS_V, 0));
        plan.push_back(reg_row(REG_AXIS_W, 0));
        plan.push_back(reg_row(REG_COS_ANGLE, 32'h2d41_3ccd));
        plan.push_back(reg_row(REG_SIN_ANGLE, 32'hd2be_c333));
        plan.push_back(pt_row(32'h1234_5678, 32'hedcb_a988, 1));
        plan.push_back(pt_row(C_MAX, C_MAX, C_MIN));
        plan.push_back(pt_row(C_MIN, C_MIN, C_MAX));
        // opposite pivot extremes, trig both at -1.0
        plan.push_back(reg_row(REG_PIVOT_X, C_MIN));
        plan.push_back(reg_row(REG_PIVOT_Y, C_MAX));
        plan.push_back(reg_row(REG_PIVOT_Z, C_MIN));
        plan.push_back(reg_row(REG_AXIS_V, T_ONE));
        plan.push_back(reg_row(REG_AXIS_W, T_NEG_ONE));
        plan.push_back(reg_row(REG_COS_ANGLE, T_NEG_ONE));
        plan.push_back(reg_row(REG_SIN_ANGLE, T_NEG_ONE));
        plan.push_back(pt_row(C_MAX, C_MIN, C_MAX));
        plan.push_back(pt_row(0, 0, 0));
        plan.push_back(pt_row(32'h0000_ffff, 32'hffff_0001, 32'h4000_0000));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < plan.size(); i++)
        begin
            row = plan[i];
            if (row.kind == ROW_REG)
            begin
                if (i == 0 || plan[i-1].kind != ROW_REG)
                    drain();
                write_reg(row.idx, row.data,
                          (i + 1 < plan.size()) && (plan[i+1].kind == ROW_REG));
            end
            else
                send_point(row.x, row.y, row.z, row.known, row.want, 1'b0);
        end

        // random phases
        for (ph = 0; ph < RAND_PHASES; ph++)
            random_phase(ph % 4, RAND_ITEMS / RAND_PHASES);

        // wait for the last results, then watch for strays
        pt_ch.valid <= 1'b0;
        waited = 0;
        while (pending.size() != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending.size() != 0)
            report_mismatch("results never arrived", 64'(pending.size()), '0);
        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("%0d points rotated, %0d expected to saturate, %0d register writes",
                 n_points, n_clipped, n_writes);
        $display("settings: reset identity, half and quarter turns, unit, raw and extreme axes");
        if (errors == 0)
            $display("point_rotation_about_axis_core: match");
        else
            $display("point_rotation_about_axis_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
